>>> design/bnms_pkg.sv
// Shared types, constants and codes for the box suppression block.
package bnms_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    // Threshold is unsigned fixed point with FRAC_BITS fraction bits.
    localparam int               THR_W     = 17;
    localparam int               FRAC_BITS = 16;
    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    typedef enum logic [0:0] {
        REG_THRESH = 1'b0,
        REG_MODE   = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        MODE_IOU   = 1'b0,
        MODE_IOMIN = 1'b1
    } ovl_mode_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_FIND,
        ST_RDA,
        ST_CAPA,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic cand_inc;
        logic rd_anchor;
        logic cap_anchor;
        logic sweep;
        logic emit;
        logic emit_last;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic cand_end;
        logic cand_alive;
        logic sweep_end;
        logic pipe_busy;
        logic out_free;
    } stat_t;

endpackage

>>> design/bnms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bnms_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/bnms_datapath.sv
// Box store, live flags, anchor registers, overlap pipeline and output register.
module bnms_datapath import bnms_pkg::*; #(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [THR_W-1:0]      threshold,
    input  ovl_mode_t             mode,
    input  logic [COORD_BITS-1:0] box_x,
    input  logic [COORD_BITS-1:0] box_y,
    input  logic [COORD_BITS-1:0] box_w,
    input  logic [COORD_BITS-1:0] box_h,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [COORD_BITS-1:0] kept_x,
    output logic [COORD_BITS-1:0] kept_y,
    output logic [COORD_BITS-1:0] kept_w,
    output logic [COORD_BITS-1:0] kept_h,
    output logic                  kept_last
);

    localparam int IDX_W   = $clog2(MAX_BOXES);
    localparam int CNT_W   = $clog2(MAX_BOXES + 1);
    localparam int C       = COORD_BITS;
    localparam int FAR_W   = C + 1;
    localparam int SIDE_W  = C + 1;
    localparam int AREA_W  = 2 * C;
    localparam int INTER_W = 2 * C + 1;
    localparam int MAG_W   = 2 * C + 2;
    localparam int DEN_W   = 2 * C + 3;
    localparam int PROD_W  = THR_W + MAG_W;
    localparam int WORD_W  = 4 * C;

    // Overlapping length of two intervals, far end inclusive plus one, clamped at zero.
    function automatic logic [SIDE_W-1:0] side_len(
        input logic [C-1:0]     na,
        input logic [FAR_W-1:0] fa,
        input logic [C-1:0]     nb,
        input logic [FAR_W-1:0] fb
    );
        logic [FAR_W-1:0] lo;
        logic [FAR_W-1:0] hi;
        logic [FAR_W:0]   hi1;
        logic [FAR_W:0]   diff;
        lo   = (na > nb) ? {1'b0, na} : {1'b0, nb};
        hi   = (fa < fb) ? fa : fb;
        hi1  = {1'b0, hi} + (FAR_W + 1)'(1);
        diff = hi1 - {1'b0, lo};
        if (hi1 > {1'b0, lo})
        begin
            return diff[SIDE_W-1:0];
        end
        return '0;
    endfunction

    // Control registers.
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     cand_reg, cand_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [MAX_BOXES-1:0] alive_reg, alive_next;
    logic                 v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers.
    logic [C-1:0]         ax_reg, ay_reg, aw_reg, ah_reg;
    logic [FAR_W-1:0]     afx_reg, afy_reg;
    logic [AREA_W-1:0]    area_a_reg;
    logic [IDX_W-1:0]     j0_reg, j1_reg, j2_reg, j3_reg, j4_reg;
    logic [SIDE_W-1:0]    sx1_reg, sy1_reg;
    logic [AREA_W-1:0]    area_b1_reg, area_b2_reg;
    logic [INTER_W-1:0]   inter2_reg, inter3_reg, inter4_reg;
    logic signed [DEN_W-1:0] den3_reg;
    logic [PROD_W-1:0]    prod4_reg;
    logic                 dz4_reg, dn4_reg;
    logic [C-1:0]         kx_reg, ky_reg, kw_reg, kh_reg;
    logic                 klast_reg;

    // Store access.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;
    logic                 full;

    assign full      = (count_reg == CNT_W'(MAX_BOXES));
    assign ram_we    = cmd.load && !full;
    assign ram_wdata = {box_x, box_y, box_w, box_h};
    assign ram_raddr = cmd.rd_anchor ? cand_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];

    bnms_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [C-1:0]     bx, by, bw, bh;
    logic [FAR_W-1:0] bfx, bfy;

    assign bx  = ram_rdata[4*C-1:3*C];
    assign by  = ram_rdata[3*C-1:2*C];
    assign bw  = ram_rdata[2*C-1:C];
    assign bh  = ram_rdata[C-1:0];
    assign bfx = {1'b0, bx} + {1'b0, bw};
    assign bfy = {1'b0, by} + {1'b0, bh};

    // Arithmetic of the overlap pipeline.
    logic [AREA_W-1:0]     area_full;
    logic [2*SIDE_W-1:0]   inter_full;
    logic [AREA_W-1:0]     area_min;
    logic [DEN_W-1:0]      den_union;
    logic signed [DEN_W-1:0] den_c;
    logic [PROD_W-1:0]     prod_full;
    logic [PROD_W-1:0]     scaled;
    logic                  over;

    assign area_full  = bw * bh;
    assign inter_full = sx1_reg * sy1_reg;
    assign area_min   = (area_a_reg < area_b2_reg) ? area_a_reg : area_b2_reg;
    assign den_union  = {3'b000, area_a_reg} + {3'b000, area_b2_reg} - {2'b00, inter2_reg};

    always_comb
    begin
        case (mode)
            MODE_IOMIN: den_c = $signed({3'b000, area_min});
            default:    den_c = $signed(den_union);
        endcase
    end

    assign prod_full = threshold * den3_reg[MAG_W-1:0];
    assign scaled    = PROD_W'({inter4_reg, {FRAC_BITS{1'b0}}});
    // A zero denominator always drops; a negative union never does.
    assign over      = dz4_reg || (!dn4_reg && (scaled > prod4_reg));

    always_comb
    begin
        count_next     = count_reg;
        cand_next      = cand_reg;
        j_next         = j_reg;
        alive_next     = alive_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            count_next = '0;
        end
        if (cmd.start)
        begin
            cand_next = '0;
            for (int k = 0; k < MAX_BOXES; k++)
            begin
                alive_next[k] = (CNT_W'(k) < count_reg);
            end
        end
        if (cmd.cand_inc)
        begin
            cand_next = cand_reg + CNT_W'(1);
        end
        if (cmd.cap_anchor)
        begin
            j_next = cand_reg + CNT_W'(1);
        end
        if (cmd.sweep)
        begin
            j_next = j_reg + CNT_W'(1);
        end
        if (v4_reg && over)
        begin
            alive_next[j4_reg] = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cand_reg      <= '0;
            j_reg         <= '0;
            alive_reg     <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cand_reg      <= cand_next;
            j_reg         <= j_next;
            alive_reg     <= alive_next;
            v0_reg        <= cmd.sweep;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_anchor)
        begin
            ax_reg     <= bx;
            ay_reg     <= by;
            aw_reg     <= bw;
            ah_reg     <= bh;
            afx_reg    <= bfx;
            afy_reg    <= bfy;
            area_a_reg <= area_full;
        end
        // Stage 0: read issued; stage 1: sides and area; 2: intersection;
        // 3: denominator; 4: threshold product.
        j0_reg      <= j_reg[IDX_W-1:0];
        j1_reg      <= j0_reg;
        sx1_reg     <= side_len(ax_reg, afx_reg, bx, bfx);
        sy1_reg     <= side_len(ay_reg, afy_reg, by, bfy);
        area_b1_reg <= area_full;
        j2_reg      <= j1_reg;
        inter2_reg  <= inter_full[INTER_W-1:0];
        area_b2_reg <= area_b1_reg;
        j3_reg      <= j2_reg;
        inter3_reg  <= inter2_reg;
        den3_reg    <= den_c;
        j4_reg      <= j3_reg;
        inter4_reg  <= inter3_reg;
        prod4_reg   <= prod_full;
        dz4_reg     <= (den3_reg == '0);
        dn4_reg     <= den3_reg[DEN_W-1];
        if (cmd.emit)
        begin
            kx_reg    <= ax_reg;
            ky_reg    <= ay_reg;
            kw_reg    <= aw_reg;
            kh_reg    <= ah_reg;
            klast_reg <= cmd.emit_last;
        end
    end

    assign stat.cand_end   = (cand_reg == count_reg);
    assign stat.cand_alive = (cand_reg < count_reg) && alive_reg[cand_reg[IDX_W-1:0]];
    assign stat.sweep_end  = (j_reg == count_reg);
    assign stat.pipe_busy  = v0_reg || v1_reg || v2_reg || v3_reg || v4_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign kept_x    = kx_reg;
    assign kept_y    = ky_reg;
    assign kept_w    = kw_reg;
    assign kept_h    = kh_reg;
    assign kept_last = klast_reg;

endmodule

>>> design/bnms_ctrl.sv
// Sequencer for loading, anchor search, sweep and result emission.
module bnms_ctrl import bnms_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  set_last,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   pending_reg, pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        cmd          = '0;
        in_stall     = 1'b1;

        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
                if (in_valid && set_last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.start    = 1'b1;
                pending_next = 1'b0;
                state_next   = ST_FIND;
            end
            ST_FIND:
            begin
                // The held anchor goes out once we know whether another box survives it.
                if (stat.cand_end)
                begin
                    if (!pending_reg)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        cmd.finish    = 1'b1;
                        pending_next  = 1'b0;
                        state_next    = ST_LOAD;
                    end
                end
                else if (stat.cand_alive)
                begin
                    if (!pending_reg)
                    begin
                        state_next = ST_RDA;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_RDA;
                    end
                end
                else
                begin
                    cmd.cand_inc = 1'b1;
                end
            end
            ST_RDA:
            begin
                cmd.rd_anchor = 1'b1;
                state_next    = ST_CAPA;
            end
            ST_CAPA:
            begin
                cmd.cap_anchor = 1'b1;
                pending_next   = 1'b1;
                state_next     = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (stat.sweep_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.sweep = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.cand_inc = 1'b1;
                    state_next   = ST_FIND;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

>>> design/box_non_max_suppression.sv
// Greedy box suppression: top level with the register port.
//
// Boxes arrive on the input channel (in_valid/in_stall), one word per box, in
// load order; set_last marks the final box of a set. Loading takes one cycle a
// box. Boxes past the store capacity are dropped, but their set_last still ends
// the set. After set_last the block stalls its input and suppresses the stored
// n boxes: a surviving anchor with index i, counted from zero, costs an anchor
// search, one read of the single-port box store per later box through one
// five-stage overlap unit, and then a drain of that unit; each dead index is
// skipped by one step of the scan.
// Kept boxes leave on the output channel (out_valid/out_stall) in load order;
// kept_last flags the final one. A stalled result holds in the output register;
// the search then waits before loading the next anchor. The input reopens as
// soon as the last kept box is in the output register.
// Reset empties the set, clears all flags and sets threshold 0.5, union mode.
// Registers: offset 0 threshold (17 bits, 65536 is 1.0), offset 4 mode.
module box_non_max_suppression import bnms_pkg::*; #(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] box_x,
    input  logic [COORD_BITS-1:0] box_y,
    input  logic [COORD_BITS-1:0] box_w,
    input  logic [COORD_BITS-1:0] box_h,
    input  logic                  set_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] kept_x,
    output logic [COORD_BITS-1:0] kept_y,
    output logic [COORD_BITS-1:0] kept_w,
    output logic [COORD_BITS-1:0] kept_h,
    output logic                  kept_last
);

    logic [THR_W-1:0] thr_reg, thr_next;
    ovl_mode_t        mode_reg, mode_next;
    reg_idx_t         reg_idx;
    logic             wr_en;
    cmd_t             cmd;
    stat_t            stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

    always_comb
    begin
        thr_next  = thr_reg;
        mode_next = mode_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_THRESH: thr_next  = pwdata[THR_W-1:0];
                REG_MODE:   mode_next = ovl_mode_t'(pwdata[0]);
                default:    thr_next  = thr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESH: prdata = APB_DW'(thr_reg);
            REG_MODE:   prdata = APB_DW'(mode_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            mode_reg <= MODE_IOU;
        end
        else
        begin
            thr_reg  <= thr_next;
            mode_reg <= mode_next;
        end
    end

    bnms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .set_last (set_last),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bnms_datapath #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .threshold (thr_reg),
        .mode      (mode_reg),
        .box_x     (box_x),
        .box_y     (box_y),
        .box_w     (box_w),
        .box_h     (box_h),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .kept_x    (kept_x),
        .kept_y    (kept_y),
        .kept_w    (kept_w),
        .kept_h    (kept_h),
        .kept_last (kept_last)
    );

endmodule

>>> design/bnms_checker.sv
// Port-level checks for the box suppression block, bound to the top level.
module bnms_checker import bnms_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  set_last,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [COORD_BITS-1:0] kept_x,
    input logic                  kept_last
);

    // The end of a set always starts suppression, which closes the input.
    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && set_last) |=> in_stall)
        else $error("input still open after the final box of a set");

    // The input only closes because a set was ended.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && set_last))
        else $error("input closed without a final box");

    // A kept box other than the last one appears only during suppression.
    a_result_in_suppress: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && !kept_last) |-> in_stall)
        else $error("non-final result while loading");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(kept_x) && $stable(kept_last)))
        else $error("stalled result word changed");

endmodule

bind box_non_max_suppression bnms_checker #(.COORD_BITS(COORD_BITS)) u_bnms_checker (.*);
